[design/rbf_pkg.sv]
`default_nettype none
package rbf_pkg;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] REG_CENTERS = 3'd0;
	localparam logic [2:0] REG_BASIS   = 3'd1;
	localparam logic [2:0] REG_PCONST  = 3'd2;
	localparam logic [2:0] REG_PX      = 3'd3;
	localparam logic [2:0] REG_PY      = 3'd4;
	localparam logic [2:0] REG_PZ      = 3'd5;
	localparam logic [2:0] REG_READY   = 3'd6;

	typedef struct packed {
		logic [10:0] centers_in_use;
		logic        basis_select;
		logic [31:0] poly_const;
		logic [31:0] poly_x;
		logic [31:0] poly_y;
		logic [31:0] poly_z;
		logic        model_ready;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  status;
		logic [9:0]  entry_index;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
		logic [31:0] weight_in;
	} entry_t;
endpackage
`default_nettype wire

[design/rbf_front.sv]
`default_nettype none
module rbf_front #(
	parameter int MAX_CENTERS = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           cmd,
	input  wire logic [9:0]     entry_index,
	input  wire logic [31:0]    coord_x,
	input  wire logic [31:0]    coord_y,
	input  wire logic [31:0]    coord_z,
	input  wire logic [31:0]    weight_in,
	input  wire logic           model_ready,
	output logic                q_valid,
	output rbf_pkg::entry_t     q_data,
	input  wire logic           q_pop
);
	rbf_pkg::entry_t fifo_q [2];
	logic            rd_ptr_q, wr_ptr_q;
	logic [1:0]      cnt_q;
	rbf_pkg::entry_t ent;
	logic            push;

	always_comb begin
		ent.cmd         = cmd;
		ent.entry_index = entry_index;
		ent.coord_x     = coord_x;
		ent.coord_y     = coord_y;
		ent.coord_z     = coord_z;
		ent.weight_in   = weight_in;
		ent.status      = rbf_pkg::ST_OK;
		if (cmd == rbf_pkg::CMD_QUERY) begin
			if (!model_ready) ent.status = rbf_pkg::ST_NOT_READY;
		end else if ({7'd0, entry_index} >= 17'(MAX_CENTERS)) begin
			ent.status = rbf_pkg::ST_RANGE;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

[design/rbf_back.sv]
`default_nettype none
module rbf_back #(
	parameter int MAX_CENTERS = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rbf_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire rbf_pkg::entry_t q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [63:0]          value_out,
	output logic [1:0]           status
);
	localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CW = $clog2(MAX_CENTERS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DIF, S_SQ, S_RT, S_CB1, S_CB2, S_CB3, S_WM1, S_WM2, S_ACC,
		S_POLY
	} state_t;

	logic [31:0] mem_x [MAX_CENTERS];
	logic [31:0] mem_y [MAX_CENTERS];
	logic [31:0] mem_z [MAX_CENTERS];
	logic [31:0] mem_w [MAX_CENTERS];

	state_t      state_q;
	logic [CW-1:0] idx_q, n_q;
	logic [31:0] qx_q, qy_q, qz_q;
	logic [31:0] cx_q, cy_q, cz_q, cw_q;
	logic [31:0] ad_q [3];
	logic [1:0]  k_q;
	logic [65:0] rad_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  step_q;
	logic [49:0] t_q;
	logic [63:0] phi_q;
	logic [95:0] prod_q;
	logic [63:0] acc_q;
	logic        ov_q;
	logic [63:0] val_q;
	logic [1:0]  st_q;

	logic        wr_en, rd_en;
	logic [AW-1:0] waddr, raddr;
	logic [16:0] n_full;
	logic [35:0] remn, trial;
	logic [32:0] d33 [3];
	logic [63:0] sq;
	logic [63:0] term, addend;
	logic [31:0] aw;
	logic        neg_w;
	logic [31:0] pc, pv;

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s;
	endfunction

	assign out_valid = ov_q;
	assign value_out = val_q;
	assign status    = st_q;

	assign q_pop  = (state_q == S_IDLE) && q_valid && !ov_q;
	assign wr_en  = q_pop && q_data.cmd == rbf_pkg::CMD_LOAD && q_data.status == rbf_pkg::ST_OK;
	assign waddr  = AW'({7'd0, q_data.entry_index});
	assign rd_en  = (state_q == S_RD);
	assign raddr  = AW'(idx_q);
	assign n_full = ({6'd0, cfg.centers_in_use} > 17'(MAX_CENTERS)) ? 17'(MAX_CENTERS)
		: {6'd0, cfg.centers_in_use};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[waddr] <= q_data.coord_x;
			mem_y[waddr] <= q_data.coord_y;
			mem_z[waddr] <= q_data.coord_z;
			mem_w[waddr] <= q_data.weight_in;
		end
		if (rd_en) begin
			cx_q <= mem_x[raddr];
			cy_q <= mem_y[raddr];
			cz_q <= mem_z[raddr];
			cw_q <= mem_w[raddr];
		end
	end

	always_comb begin
		d33[0] = {qx_q[31], qx_q} - {cx_q[31], cx_q};
		d33[1] = {qy_q[31], qy_q} - {cy_q[31], cy_q};
		d33[2] = {qz_q[31], qz_q} - {cz_q[31], cz_q};
		sq     = {32'd0, ad_q[k_q]} * {32'd0, ad_q[k_q]};
		remn   = {rem_q[33:0], rad_q[65:64]};
		trial  = {1'b0, root_q[32:0], 2'b01};
		neg_w  = cw_q[31];
		aw     = neg_w ? (32'd0 - cw_q) : cw_q;
		term   = 64'd0;
		if (prod_q[95:64] != 32'd0) begin
			term = neg_w ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else if (neg_w) begin
			term = prod_q[63] ? 64'h8000_0000_0000_0000 : (64'd0 - prod_q[63:0]);
		end else begin
			term = prod_q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : prod_q[63:0];
		end
		case (k_q)
			2'd1:    begin pc = cfg.poly_x; pv = qx_q; end
			2'd2:    begin pc = cfg.poly_y; pv = qy_q; end
			default: begin pc = cfg.poly_z; pv = qz_q; end
		endcase
		if (k_q == 2'd0)
			addend = {{16{cfg.poly_const[31]}}, cfg.poly_const, 16'd0};
		else
			addend = 64'($signed(pc) * $signed(pv));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
			k_q     <= 2'd0;
			step_q  <= 6'd0;
			st_q    <= rbf_pkg::ST_OK;
			val_q   <= 64'd0;
			acc_q   <= 64'd0;
			qx_q    <= 32'd0;
			qy_q    <= 32'd0;
			qz_q    <= 32'd0;
			rad_q   <= 66'd0;
			rem_q   <= 36'd0;
			root_q  <= 33'd0;
			t_q     <= 50'd0;
			phi_q   <= 64'd0;
			prod_q  <= 96'd0;
			for (int j = 0; j < 3; j++) ad_q[j] <= 32'd0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						qx_q  <= q_data.coord_x;
						qy_q  <= q_data.coord_y;
						qz_q  <= q_data.coord_z;
						acc_q <= 64'd0;
						idx_q <= '0;
						k_q   <= 2'd0;
						n_q   <= CW'(n_full);
						if (q_data.cmd == rbf_pkg::CMD_QUERY && q_data.status == rbf_pkg::ST_OK) begin
							state_q <= (n_full == 17'd0) ? S_POLY : S_RD;
						end else begin
							ov_q  <= 1'b1;
							val_q <= 64'd0;
							st_q  <= q_data.status;
						end
					end
				end
				S_RD: state_q <= S_DIF;
				S_DIF: begin
					for (int j = 0; j < 3; j++)
						ad_q[j] <= d33[j][32] ? 32'(33'd0 - d33[j]) : d33[j][31:0];
					rad_q   <= 66'd0;
					k_q     <= 2'd0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					rad_q <= rad_q + {2'd0, sq};
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						rem_q   <= 36'd0;
						root_q  <= 33'd0;
						step_q  <= 6'd0;
						state_q <= S_RT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_RT: begin
					rad_q <= {rad_q[63:0], 2'b00};
					if (remn >= trial) begin
						rem_q  <= remn - trial;
						root_q <= {root_q[31:0], 1'b1};
					end else begin
						rem_q  <= remn;
						root_q <= {root_q[31:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'd32) state_q <= cfg.basis_select ? S_CB1 : S_WM1;
				end
				S_WM1: begin
					if (state_q == S_WM1 && !cfg.basis_select) phi_q <= {31'd0, root_q};
					state_q <= S_WM2;
					prod_q  <= 96'd0;
				end
				S_CB1: begin
					t_q     <= 50'(({33'd0, root_q} * {33'd0, root_q}) >> 16);
					state_q <= S_CB2;
				end
				S_CB2: begin
					prod_q  <= {38'd0, {33'd0, t_q[24:0]} * {25'd0, root_q}};
					state_q <= S_CB3;
				end
				S_CB3: begin
					logic [95:0] p;
					p = prod_q + ({38'd0, {33'd0, t_q[49:25]} * {25'd0, root_q}} << 25);
					phi_q   <= (p[83:80] != 4'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[79:16];
					prod_q  <= 96'd0;
					state_q <= S_WM2;
				end
				S_WM2: begin
					prod_q  <= {32'd0, 64'({32'd0, aw} * {32'd0, phi_q[31:0]})};
					state_q <= S_ACC;
					k_q     <= 2'd1;
				end
				S_ACC: begin
					if (k_q == 2'd1) begin
						prod_q <= prod_q + ({32'd0, 64'({32'd0, aw} * {32'd0, phi_q[63:32]})} << 32);
						k_q    <= 2'd0;
					end else begin
						acc_q <= sadd(acc_q, term);
						idx_q <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == n_q) ? S_POLY : S_RD;
					end
				end
				S_POLY: begin
					acc_q <= sadd(acc_q, addend);
					if (k_q == 2'd3) begin
						k_q     <= 2'd0;
						ov_q    <= 1'b1;
						val_q   <= sadd(acc_q, addend);
						st_q    <= rbf_pkg::ST_OK;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/rbf_interpolant_evaluate_unit.sv]
// Fixed-point radial basis interpolant evaluator in three dimensions.
// The in channel takes one item per handshake: a load writes one center and
// its weight, a query asks for the interpolant value at a point.
// The out channel returns exactly one item per input item, in order.
// The cfg channel writes one register per handshake; it is always ready.
// A two-item queue sits between the front end and the evaluator, so items
// are accepted while a result waits on a stalled receiver.
// Loads and refused items are answered from the idle state without a
// computation. A query works through every center in use with the linear
// or the cubic basis; the iterative square root forms each distance, one
// result bit per cycle.
// When the receiver stalls, the result holds and the queue fills, after
// which in_ready drops.
// Reset clears the control registers and empties the queue; the center
// store is not cleared and must be loaded before it is queried.
`default_nettype none
module rbf_interpolant_evaluate_unit #(
	parameter int MAX_CENTERS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [9:0]  entry_index,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [31:0] coord_z,
	input  wire logic [31:0] weight_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value_out,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	rbf_pkg::cfg_t   cfg_q;
	rbf_pkg::entry_t q_data;
	logic            q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rbf_pkg::REG_CENTERS: cfg_q.centers_in_use <= cfg_data[10:0];
				rbf_pkg::REG_BASIS:   cfg_q.basis_select   <= cfg_data[0];
				rbf_pkg::REG_PCONST:  cfg_q.poly_const     <= cfg_data;
				rbf_pkg::REG_PX:      cfg_q.poly_x         <= cfg_data;
				rbf_pkg::REG_PY:      cfg_q.poly_y         <= cfg_data;
				rbf_pkg::REG_PZ:      cfg_q.poly_z         <= cfg_data;
				rbf_pkg::REG_READY:   cfg_q.model_ready    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rbf_front #(.MAX_CENTERS(MAX_CENTERS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .entry_index(entry_index), .coord_x(coord_x), .coord_y(coord_y),
		.coord_z(coord_z), .weight_in(weight_in), .model_ready(cfg_q.model_ready),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	rbf_back #(.MAX_CENTERS(MAX_CENTERS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
		.value_out(value_out), .status(status)
	);
endmodule
`default_nettype wire

[design/rbf_checker.sv]
`default_nettype none
module rbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] value_out,
	input wire logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status))
		else $error("stalled result changed");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rbf_pkg::ST_OK |-> value_out == 64'd0)
		else $error("refused item carries a value");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");
endmodule

bind rbf_interpolant_evaluate_unit rbf_checker u_rbf_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.value_out(value_out), .status(status)
);
`default_nettype wire
